// ----- rtl/core/i2cm_pkg.sv -----
// Shared types, codes and the microcode program of the I2C master byte engine.
// Used by i2cm_seq, i2cm_datapath and i2c_master_byte_engine; depends on nothing.
`timescale 1ns / 1ps

package i2cm_pkg;

  // Byte geometry.
  localparam int BITS_PER_BYTE = 8;
  localparam int CNT_W         = $clog2(BITS_PER_BYTE);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_BYTE - 1);

  // Field widths.
  localparam int MODE_W = 3;
  localparam int HOLD_W = 16;
  localparam int PC_W   = 5;

  // Register reset values and indexes.
  localparam logic [HOLD_W-1:0] PHASE_HOLD_RESET = HOLD_W'(100);
  localparam logic [HOLD_W-1:0] ACK_HOLD_RESET   = HOLD_W'(1000);
  localparam logic REG_PHASE_HOLD = 1'b0;
  localparam logic REG_ACK_HOLD   = 1'b1;

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_START = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STOP  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ACK   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_NACK  = 3'd5;

  // Line operations; OP_BIT takes the data line from the shift register.
  localparam logic [1:0] OP_KEEP = 2'd0;
  localparam logic [1:0] OP_LOW  = 2'd1;
  localparam logic [1:0] OP_HIGH = 2'd2;
  localparam logic [1:0] OP_BIT  = 2'd3;

  // Hold time selection.
  localparam logic [1:0] HOLD_PHASE = 2'd0;
  localparam logic [1:0] HOLD_ACK   = 2'd1;
  localparam logic [1:0] HOLD_ZERO  = 2'd2;

  // Program entry points.
  localparam logic [PC_W-1:0] ADDR_START = 5'd0;
  localparam logic [PC_W-1:0] ADDR_STOP  = 5'd4;
  localparam logic [PC_W-1:0] ADDR_NACK  = 5'd7;
  localparam logic [PC_W-1:0] ADDR_ACK   = 5'd11;
  localparam logic [PC_W-1:0] ADDR_WRITE = 5'd15;
  localparam logic [PC_W-1:0] ADDR_READ  = 5'd23;
  localparam logic [PC_W-1:0] ADDR_RBIT  = 5'd24;
  localparam logic [PC_W-1:0] ADDR_END   = 5'd26;

  // One control word of the program.
  typedef struct packed {
    logic [1:0]      scl_op;
    logic [1:0]      sda_op;
    logic [1:0]      dir_op;
    logic [1:0]      hold_sel;
    logic            sample;
    logic            shift;
    logic            loop;
    logic            last;
    logic            fin_rd;
    logic            fin_ack;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Step issued from the sequencer to the datapath.
  typedef struct packed {
    logic  fire;
    logic  last;
    ctrl_t ctrl;
  } step_t;

  // Entry point of a command; valid reports whether the code is a command.
  function automatic logic [PC_W:0] mode_entry(input logic [MODE_W-1:0] mode);
    logic [PC_W:0] e;
    case (mode)
      MODE_START: e = {1'b1, ADDR_START};
      MODE_STOP:  e = {1'b1, ADDR_STOP};
      MODE_WRITE: e = {1'b1, ADDR_WRITE};
      MODE_READ:  e = {1'b1, ADDR_READ};
      MODE_ACK:   e = {1'b1, ADDR_ACK};
      MODE_NACK:  e = {1'b1, ADDR_NACK};
      default:    e = '0;
    endcase
    return e;
  endfunction

  // The microcode program. A loop word jumps back to its target until the
  // last bit is done; its last flag only counts on the final pass.
  function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '0;
    case (pc)
      // Start condition.
      5'd0:  w.sda_op = OP_HIGH;
      5'd1:  w.scl_op = OP_HIGH;
      5'd2:  w.sda_op = OP_LOW;
      5'd3:  begin w.scl_op = OP_LOW; w.last = 1'b1; end
      // Stop condition.
      5'd4:  w.sda_op = OP_LOW;
      5'd5:  w.scl_op = OP_HIGH;
      5'd6:  begin w.sda_op = OP_HIGH; w.last = 1'b1; end
      // Not-acknowledge.
      5'd7:  w.sda_op = OP_HIGH;
      5'd8:  w.scl_op = OP_HIGH;
      5'd9:  w.scl_op = OP_LOW;
      5'd10: begin w.sda_op = OP_LOW; w.last = 1'b1; end
      // Acknowledge: take the line and pull it low.
      5'd11: begin w.dir_op = OP_HIGH; w.sda_op = OP_LOW; end
      5'd12: w.scl_op = OP_HIGH;
      5'd13: w.scl_op = OP_LOW;
      5'd14: begin w.sda_op = OP_HIGH; w.hold_sel = HOLD_ZERO; w.last = 1'b1; end
      // Byte write, MSB first, then the slave acknowledge.
      5'd15: begin w.sda_op = OP_BIT; w.shift = 1'b1; end
      5'd16: w.scl_op = OP_HIGH;
      5'd17: begin w.scl_op = OP_LOW; w.loop = 1'b1; w.target = ADDR_WRITE; end
      5'd18: w = '0;
      5'd19: w.dir_op = OP_LOW;
      5'd20: begin w.scl_op = OP_HIGH; w.hold_sel = HOLD_ACK; w.sample = 1'b1; end
      5'd21: w.scl_op = OP_LOW;
      5'd22: begin
        w.dir_op = OP_HIGH; w.hold_sel = HOLD_ZERO; w.last = 1'b1; w.fin_ack = 1'b1;
      end
      // Byte read with the line released.
      5'd23: w.dir_op = OP_LOW;
      5'd24: w = '0;
      5'd25: begin w.scl_op = OP_HIGH; w.sample = 1'b1; end
      5'd26: begin
        w.scl_op = OP_LOW; w.loop = 1'b1; w.target = ADDR_RBIT;
        w.last = 1'b1; w.fin_rd = 1'b1;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/i2cm_seq.sv -----
// Microcode sequencer: step counter, bit counter and conditional loop jumps.
// Reads the program from i2cm_pkg::rom and issues one step per free output slot.
`timescale 1ns / 1ps

module i2cm_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [i2cm_pkg::MODE_W-1:0]     mode,
  input  logic                            out_free,
  output logic                            busy,
  output i2cm_pkg::step_t                 step
);

  logic [i2cm_pkg::PC_W-1:0]  pc;
  logic [i2cm_pkg::CNT_W-1:0] cnt;
  logic [i2cm_pkg::PC_W:0]    entry;
  i2cm_pkg::ctrl_t            ctrl;
  logic                       looping;

  // Decode the current control word and whether a loop jumps back.
  always_comb begin
    ctrl       = i2cm_pkg::rom(pc);
    entry      = i2cm_pkg::mode_entry(mode);
    looping    = ctrl.loop && (cnt != i2cm_pkg::LAST_BIT);
    step.fire  = busy && out_free;
    step.last  = ctrl.last && !looping;
    step.ctrl  = ctrl;
  end

  // Step counter and bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
      cnt  <= '0;
    end else if (!busy) begin
      if (load && entry[i2cm_pkg::PC_W]) begin
        busy <= 1'b1;
        pc   <= entry[i2cm_pkg::PC_W-1:0];
        cnt  <= '0;
      end
    end else if (step.fire) begin
      if (step.last) begin
        busy <= 1'b0;
      end else if (looping) begin
        pc  <= ctrl.target;
        cnt <= cnt + 1'b1;
      end else begin
        pc <= pc + 1'b1;
        if (ctrl.loop) begin
          cnt <= '0;
        end
      end
    end
  end

  // The program counter stays inside the program.
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc <= i2cm_pkg::ADDR_END))
    else $error("sequencer left the program");

  // A finished command frees the sequencer.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (step.fire && step.last) |=> !busy)
    else $error("sequencer still busy after the last step");

  // A loop jump only happens on a loop word.
  a_loop_jump: assert property (@(posedge clk) disable iff (rst)
    (step.fire && looping) |=> (pc == i2cm_pkg::ADDR_WRITE || pc == i2cm_pkg::ADDR_RBIT))
    else $error("loop jumped to a bad target");

endmodule

// ----- rtl/core/i2cm_datapath.sv -----
// Line-state datapath: SCL, SDA and direction registers, the write shift
// register and the output word register. Uses i2cm_pkg types and codes.
`timescale 1ns / 1ps

module i2cm_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [7:0]                  write_data,
  input  logic [7:0]                  line_bits,
  input  logic                        line_ack,
  input  logic [i2cm_pkg::HOLD_W-1:0] phase_hold,
  input  logic [i2cm_pkg::HOLD_W-1:0] ack_hold,
  input  i2cm_pkg::step_t             step,
  input  logic                        out_stall,
  output logic                        out_free,
  output logic                        out_valid,
  output logic                        scl,
  output logic                        sda_level,
  output logic                        sda_driven,
  output logic [i2cm_pkg::HOLD_W-1:0] hold_time,
  output logic                        sample_point,
  output logic [7:0]                  read_data,
  output logic                        acked,
  output logic                        last
);

  logic                        scl_state;
  logic                        sda_state;
  logic                        sda_direction;
  logic                        scl_next;
  logic                        sda_next;
  logic                        dir_next;
  logic [7:0]                  shift_reg;
  logic [7:0]                  bits_q;
  logic                        ack_q;
  logic [i2cm_pkg::HOLD_W-1:0] hold_next;

  assign out_free = !out_valid || !out_stall;

  // Apply the line operations of the current step.
  always_comb begin
    case (step.ctrl.scl_op)
      i2cm_pkg::OP_LOW:  scl_next = 1'b0;
      i2cm_pkg::OP_HIGH: scl_next = 1'b1;
      default:           scl_next = scl_state;
    endcase
    case (step.ctrl.sda_op)
      i2cm_pkg::OP_LOW:  sda_next = 1'b0;
      i2cm_pkg::OP_HIGH: sda_next = 1'b1;
      i2cm_pkg::OP_BIT:  sda_next = shift_reg[7];
      default:           sda_next = sda_state;
    endcase
    case (step.ctrl.dir_op)
      i2cm_pkg::OP_LOW:  dir_next = 1'b0;
      i2cm_pkg::OP_HIGH: dir_next = 1'b1;
      default:           dir_next = sda_direction;
    endcase
    case (step.ctrl.hold_sel)
      i2cm_pkg::HOLD_ACK:  hold_next = ack_hold;
      i2cm_pkg::HOLD_ZERO: hold_next = '0;
      default:             hold_next = phase_hold;
    endcase
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scl_state     <= 1'b1;
      sda_state     <= 1'b1;
      sda_direction <= 1'b1;
    end else if (step.fire) begin
      scl_state     <= scl_next;
      sda_state     <= sda_next;
      sda_direction <= dir_next;
    end
  end

  // Command operands and the write shift register.
  always_ff @(posedge clk) begin
    if (load) begin
      shift_reg <= write_data;
      bits_q    <= line_bits;
      ack_q     <= line_ack;
    end else if (step.fire && step.ctrl.shift) begin
      shift_reg <= {shift_reg[6:0], 1'b0};
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      scl          <= scl_next;
      sda_level    <= sda_next;
      sda_driven   <= dir_next;
      hold_time    <= hold_next;
      sample_point <= step.ctrl.sample;
      read_data    <= (step.last && step.ctrl.fin_rd) ? bits_q : 8'd0;
      acked        <= step.last && step.ctrl.fin_ack && !ack_q;
      last         <= step.last;
    end
  end

  // Sampling happens only with the clock line high.
  a_sample_scl: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sample_point) |-> scl)
    else $error("sample point with clock low");

  // Status fields are only reported on the final word.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (acked || read_data != 8'd0)) |-> last)
    else $error("status reported before the final word");

  // A step never overwrites a word that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    step.fire |-> out_free)
    else $error("output word overwritten while stalled");

endmodule

// ----- rtl/core/i2c_master_byte_engine.sv -----
// Top level of the I2C master byte engine: configuration registers, input
// handshake and the sequencer and datapath. Depends on i2cm_pkg, i2cm_seq, i2cm_datapath.
// The first phase word is registered from the first step after a command is accepted.
// Throughput: one phase word per cycle from the microcode step counter while the
// output is free; phases per command: start 4, stop 3, ack 4, nack 4, write 29, read 25.
// Reset: synchronous; SCL, SDA and drive state start high; holds reset to 100 and 1000.
`timescale 1ns / 1ps

module i2c_master_byte_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [i2cm_pkg::HOLD_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [i2cm_pkg::MODE_W-1:0] mode,
  input  logic [7:0]                  write_data,
  input  logic [7:0]                  line_bits,
  input  logic                        line_ack,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        scl,
  output logic                        sda_level,
  output logic                        sda_driven,
  output logic [i2cm_pkg::HOLD_W-1:0] hold_time,
  output logic                        sample_point,
  output logic [7:0]                  read_data,
  output logic                        acked,
  output logic                        last
);

  logic [i2cm_pkg::HOLD_W-1:0] phase_hold;
  logic [i2cm_pkg::HOLD_W-1:0] ack_hold;
  logic                        busy;
  logic                        load;
  logic                        out_free;
  i2cm_pkg::step_t             step;

  // A new command word is taken whenever the sequencer is idle.
  assign in_stall = busy;
  assign load     = in_valid && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_hold <= i2cm_pkg::PHASE_HOLD_RESET;
      ack_hold   <= i2cm_pkg::ACK_HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cm_pkg::REG_PHASE_HOLD: phase_hold <= cfg_data;
        i2cm_pkg::REG_ACK_HOLD:   ack_hold   <= cfg_data;
        default:                  phase_hold <= phase_hold;
      endcase
    end
  end

  i2cm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .mode     (mode),
    .out_free (out_free),
    .busy     (busy),
    .step     (step)
  );

  i2cm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .write_data   (write_data),
    .line_bits    (line_bits),
    .line_ack     (line_ack),
    .phase_hold   (phase_hold),
    .ack_hold     (ack_hold),
    .step         (step),
    .out_stall    (out_stall),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .scl          (scl),
    .sda_level    (sda_level),
    .sda_driven   (sda_driven),
    .hold_time    (hold_time),
    .sample_point (sample_point),
    .read_data    (read_data),
    .acked        (acked),
    .last         (last)
  );

endmodule
